FILE: src/sql_script_statement_splitter_macros.svh
// ----------------------------------------------------------------------------
// SQL script statement splitter: assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SQL_SCRIPT_STATEMENT_SPLITTER_MACROS_SVH
`define SQL_SCRIPT_STATEMENT_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define SQLSS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion on the block clock and reset.
`define SQLSS_ASSERT(lbl, prop, msg) \
  `SQLSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define SQLSS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SQLSS_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: src/sqlss_pkg.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter: package
// Shared constants, state and result types, and the line count view.
// ----------------------------------------------------------------------------
package sqlss_pkg;

  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned LINE_OUT_W  = 16;

  typedef logic [LINE_BITS-1:0]  line_cnt_t;
  typedef logic [LINE_OUT_W-1:0] line_out_t;
  typedef logic [1:0]            res_cnt_t;

  typedef enum logic [11:0] {
    ST_NORMAL       = 12'b0000_0000_0001,
    ST_QUOTE        = 12'b0000_0000_0010,
    ST_LINE_COMMENT = 12'b0000_0000_0100,
    ST_BLOCK        = 12'b0000_0000_1000,
    ST_BLOCK_STAR   = 12'b0000_0001_0000,
    ST_QUOTE_ESC    = 12'b0000_0010_0000,
    ST_SLASH        = 12'b0000_0100_0000,
    ST_CR           = 12'b0000_1000_0000,
    ST_DASH         = 12'b0001_0000_0000,
    ST_DOLLAR       = 12'b0010_0000_0000,
    ST_PARAM        = 12'b0100_0000_0000,
    ST_HALT         = 12'b1000_0000_0000
  } scan_state_e;

  typedef enum logic [2:0] {
    KIND_BYTE       = 3'd0,
    KIND_NAME       = 3'd1,
    KIND_PARAM_END  = 3'd2,
    KIND_CMD_END    = 3'd3,
    KIND_SCRIPT_END = 3'd4,
    KIND_ERROR      = 3'd5
  } kind_e;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    kind_e     kind;
    logic [7:0] text_byte;
    line_out_t line_number;
    logic      last_of_run;
  } result_t;

  // All results caused by one item, oldest in slot 0.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    res_cnt_t                  count;
  } bundle_t;

  typedef struct packed {
    scan_state_e st;
    logic        quote_dq;
    logic        param_in_quote;
    line_cnt_t   line_cnt;
    logic        nonempty;
  } scan_ctx_t;

  localparam line_cnt_t LINE_ONE = line_cnt_t'(1);

  // The line count as shown on the output, saturated to the port width.
  function automatic line_out_t line_view(line_cnt_t cnt);
    logic [LINE_BITS+LINE_OUT_W-1:0] wide;
    wide = {{LINE_OUT_W{1'b0}}, cnt};
    if (wide > (LINE_BITS+LINE_OUT_W)'({LINE_OUT_W{1'b1}})) begin
      return {LINE_OUT_W{1'b1}};
    end
    return wide[LINE_OUT_W-1:0];
  endfunction

endpackage

FILE: src/sqlss_stream_if.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter: stream interfaces
// Valid/ready channels for script bytes in and results out.
// ----------------------------------------------------------------------------
interface sqlss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       end_of_script;

  modport source (output valid, output script_byte, output end_of_script, input ready);
  modport sink   (input valid, input script_byte, input end_of_script, output ready);
endinterface

interface sqlss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  text_byte;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, output kind, output text_byte, output line_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input text_byte, input line_number,
                  input last_of_run, output ready);
endinterface

FILE: src/sqlss_scan.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter: scanner step
// Next scan context and the results of one script byte, all combinational.
// ----------------------------------------------------------------------------
module sqlss_scan (
  input  sqlss_pkg::scan_ctx_t ctx_i,
  input  logic                 use_variables_i,
  input  logic [7:0]           script_byte_i,
  input  logic                 end_of_script_i,
  output sqlss_pkg::scan_ctx_t ctx_o,
  output sqlss_pkg::bundle_t   bundle_o
);
  import sqlss_pkg::*;

  typedef struct packed {
    scan_ctx_t ctx;
    bundle_t   b;
  } work_t;

  function automatic work_t emit(work_t w, kind_e k, logic [7:0] c);
    result_t r;
    logic    is_text;
    is_text       = (k == KIND_BYTE) || (k == KIND_NAME);
    r.kind        = k;
    r.text_byte   = is_text ? c : 8'h00;
    r.line_number = line_view(w.ctx.line_cnt);
    r.last_of_run = 1'b0;
    if (is_text) begin
      w.ctx.nonempty = 1'b1;
    end
    case (w.b.count)
      2'd0: w.b.res[0] = r;
      2'd1: w.b.res[1] = r;
      2'd2: w.b.res[2] = r;
      default: ;
    endcase
    if (w.b.count != 2'd3) begin
      w.b.count = w.b.count + 2'd1;
    end
    return w;
  endfunction

  function automatic work_t count_line(work_t w);
    if (w.ctx.line_cnt != '1) begin
      w.ctx.line_cnt = w.ctx.line_cnt + LINE_ONE;
    end
    return w;
  endfunction

  function automatic work_t normal_byte(work_t w, logic [7:0] c, logic use_var);
    w.ctx.st = ST_NORMAL;
    priority if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      w.ctx.quote_dq = (c == CH_DQUOTE);
      w = emit(w, KIND_BYTE, c);
      w.ctx.st = ST_QUOTE;
    end else if (c == CH_SEMI) begin
      if (w.ctx.nonempty) begin
        w = emit(w, KIND_CMD_END, 8'h00);
      end
      w.ctx.nonempty = 1'b0;
    end else if (c == CH_HASH) begin
      w.ctx.st = ST_LINE_COMMENT;
    end else if (c == CH_CR) begin
      w.ctx.st = ST_CR;
    end else if (c == CH_LF) begin
      w = count_line(w);
    end else if (c == CH_SLASH) begin
      w.ctx.st = ST_SLASH;
    end else if ((c == CH_DOLLAR) && use_var) begin
      w.ctx.param_in_quote = 1'b0;
      w.ctx.st = ST_DOLLAR;
    end else if (c == CH_DASH) begin
      w.ctx.st = ST_DASH;
    end else begin
      w = emit(w, KIND_BYTE, c);
    end
    return w;
  endfunction

  function automatic work_t quote_byte(work_t w, logic [7:0] c, logic use_var);
    logic [7:0] own;
    own = w.ctx.quote_dq ? CH_DQUOTE : CH_SQUOTE;
    w.ctx.st = ST_QUOTE;
    priority if (c == own) begin
      w = emit(w, KIND_BYTE, c);
      w.ctx.st = ST_NORMAL;
    end else if (c == CH_BSLASH) begin
      w = emit(w, KIND_BYTE, c);
      w.ctx.st = ST_QUOTE_ESC;
    end else if ((c == CH_DOLLAR) && use_var) begin
      w.ctx.param_in_quote = 1'b1;
      w.ctx.st = ST_DOLLAR;
    end else begin
      w = emit(w, KIND_BYTE, c);
    end
    return w;
  endfunction

  work_t      w;
  logic [7:0] c;
  scan_state_e back_st;

  always_comb begin
    c       = script_byte_i;
    w.ctx   = ctx_i;
    w.b     = '0;
    back_st = ctx_i.param_in_quote ? ST_QUOTE : ST_NORMAL;

    unique case (ctx_i.st)
      ST_QUOTE: begin
        w = quote_byte(w, c, use_variables_i);
      end
      ST_QUOTE_ESC: begin
        w = emit(w, KIND_BYTE, c);
        w.ctx.st = ST_QUOTE;
      end
      ST_LINE_COMMENT: begin
        if (c == CH_CR) begin
          w.ctx.st = ST_CR;
        end else if (c == CH_LF) begin
          w = count_line(w);
          w.ctx.st = ST_NORMAL;
        end
      end
      ST_BLOCK, ST_BLOCK_STAR: begin
        priority if ((ctx_i.st == ST_BLOCK_STAR) && (c == CH_SLASH)) begin
          w.ctx.st = ST_NORMAL;
        end else if (c == CH_STAR) begin
          w.ctx.st = ST_BLOCK_STAR;
        end else begin
          if (c == CH_LF) begin
            w = count_line(w);
          end
          w.ctx.st = ST_BLOCK;
        end
      end
      ST_CR: begin
        if (c == CH_LF) begin
          w = count_line(w);
          w.ctx.st = ST_NORMAL;
        end else begin
          w = emit(w, KIND_ERROR, 8'h00);
          w.ctx.st = ST_HALT;
        end
      end
      ST_SLASH: begin
        priority if (c == CH_STAR) begin
          w.ctx.st = ST_BLOCK;
        end else if (c == CH_SLASH) begin
          w.ctx.st = ST_LINE_COMMENT;
        end else begin
          w = emit(w, KIND_BYTE, CH_SLASH);
          w = normal_byte(w, c, use_variables_i);
        end
      end
      ST_DASH: begin
        if (c == CH_DASH) begin
          w.ctx.st = ST_LINE_COMMENT;
        end else begin
          w = emit(w, KIND_BYTE, CH_DASH);
          w = normal_byte(w, c, use_variables_i);
        end
      end
      ST_DOLLAR: begin
        if (c == CH_DOLLAR) begin
          w = emit(w, KIND_BYTE, CH_DOLLAR);
          w.ctx.st = back_st;
        end else begin
          w = emit(w, KIND_NAME, c);
          w.ctx.st = ST_PARAM;
        end
      end
      ST_PARAM: begin
        if (c == CH_DOLLAR) begin
          w = emit(w, KIND_PARAM_END, 8'h00);
          w.ctx.st = back_st;
        end else begin
          w = emit(w, KIND_NAME, c);
        end
      end
      ST_HALT: ;
      default: begin
        w = normal_byte(w, c, use_variables_i);
      end
    endcase

    if (end_of_script_i) begin
      if (w.ctx.st == ST_QUOTE_ESC) begin
        w = emit(w, KIND_ERROR, 8'h00);
      end
      w = emit(w, KIND_SCRIPT_END, 8'h00);
      w.ctx.st             = ST_NORMAL;
      w.ctx.quote_dq       = 1'b0;
      w.ctx.param_in_quote = 1'b0;
      w.ctx.line_cnt       = LINE_ONE;
      w.ctx.nonempty       = 1'b0;
    end

    case (w.b.count)
      2'd1: w.b.res[0].last_of_run = 1'b1;
      2'd2: w.b.res[1].last_of_run = 1'b1;
      2'd3: w.b.res[2].last_of_run = 1'b1;
      default: ;
    endcase
  end

  assign ctx_o    = w.ctx;
  assign bundle_o = w.b;

endmodule

FILE: src/sqlss_outq.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter: result queue
// Two bundle slots (output and skid) drained one result per handshake.
// ----------------------------------------------------------------------------
module sqlss_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sqlss_pkg::bundle_t bundle_i,
  output logic               space_o,
  sqlss_out_if.source        out_if
);
  import sqlss_pkg::*;

  bundle_t  out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  res_cnt_t idx_q;
  logic     fire, last_pick, done;
  result_t  cur;

  assign cur       = out_q.res[idx_q];
  assign fire      = out_valid_q && out_if.ready;
  assign last_pick = (idx_q == res_cnt_t'(out_q.count - 2'd1));
  assign done      = fire && last_pick;
  assign space_o   = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (!out_valid_q || done) begin
        idx_q <= '0;
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else begin
        if (fire) begin
          idx_q <= idx_q + 2'd1;
        end
        if (push_i) begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || done) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= bundle_i;
      end
    end else if (push_i) begin
      skid_q <= bundle_i;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.kind        = cur.kind;
  assign out_if.text_byte   = cur.text_byte;
  assign out_if.line_number = cur.line_number;
  assign out_if.last_of_run = cur.last_of_run;

endmodule

FILE: src/sql_script_statement_splitter.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter
// Splits a byte stream of SQL script into commands, strips comments.
// ----------------------------------------------------------------------------
// The block takes one script byte per item and returns one to three results per byte, or none
// for bytes that are swallowed (comment text, the second half of a comment marker, a pending
// '/', '-' or '$'). Each byte is scanned in the cycle it is accepted: the scanner context is a
// register, and all results of the byte are written together into a result slot. The output
// hands these results out one per handshake, so a stream whose bytes each yield at most one
// result runs at one item per clock cycle unless the output stalls; a byte with several results
// holds the output for one handshake each. A second result slot lets a new item enter while
// the previous item's results still wait, and the input stalls only when both slots are full.
// Configuration (the use_variables bit) is written through cfg_we_i and cfg_wdata_i and takes
// effect for the next item; it should be changed only while the block is idle.
// ----------------------------------------------------------------------------
`include "sql_script_statement_splitter_macros.svh"

module sql_script_statement_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  sqlss_in_if.sink    script_in,
  sqlss_out_if.source result_out
);
  import sqlss_pkg::*;

  // Scanner context: lookahead state, quote flavor, line count and whether the current
  // command has produced any text yet.
  scan_ctx_t ctx_q, ctx_d;
  logic      use_variables_q;
  bundle_t   bundle;
  logic      accept, space;
  logic      ctx_at_reset, send_shown;

  assign script_in.ready = space;
  assign accept          = script_in.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_variables_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_variables_q <= cfg_wdata_i;
    end
  end

  sqlss_scan u_scan (
    .ctx_i           (ctx_q),
    .use_variables_i (use_variables_q),
    .script_byte_i   (script_in.script_byte),
    .end_of_script_i (script_in.end_of_script),
    .ctx_o           (ctx_d),
    .bundle_o        (bundle)
  );

  // The context advances only on an accepted item; stalled bytes leave it untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.st             <= ST_NORMAL;
      ctx_q.quote_dq       <= 1'b0;
      ctx_q.param_in_quote <= 1'b0;
      ctx_q.line_cnt       <= LINE_ONE;
      ctx_q.nonempty       <= 1'b0;
    end else if (accept) begin
      ctx_q <= ctx_d;
    end
  end

  // Items that produce no result never touch the result queue.
  sqlss_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept && (bundle.count != 2'd0)),
    .bundle_i (bundle),
    .space_o  (space),
    .out_if   (result_out)
  );

  // Views used by the checks below.
  assign ctx_at_reset = (ctx_q.st == ST_NORMAL) && (ctx_q.line_cnt == LINE_ONE) &&
                        !ctx_q.nonempty;
  assign send_shown   = result_out.valid && (result_out.kind == KIND_SCRIPT_END);

  // A stalled input means both slots are full, so a result must be on offer.
  `SQLSS_ASSERT(a_stall_has_output, !script_in.ready |-> result_out.valid, "stall without output")
  // The line count starts at one and never wraps to zero.
  `SQLSS_ASSERT(a_line_nonzero, ctx_q.line_cnt != '0, "line count is zero")
  // The end of the script returns the scanner to its reset context.
  `SQLSS_ASSERT(a_eos_resets, accept && script_in.end_of_script |=> ctx_at_reset, "ctx not reset")
  // The script-end result is always the final result of its item.
  `SQLSS_ASSERT(a_send_last, send_shown |-> result_out.last_of_run, "script end not last")

endmodule
